// ----- hdl/uqpd_pkg.sv -----
// Shared types, character codes and helper functions of the query decoder.
package uqpd_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_query;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       has_value;
      logic       run_last;
   } rsp_type;

   // All results that one input item causes, oldest in slot 0.
   typedef struct packed {
      logic [COUNT_W-1:0]              count;
      rsp_type [MAX_RESULTS-1:0]       slot;
   } bundle_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         n = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         n = c[3:0] + 4'd9;
      end
      return n;
   endfunction

   function automatic logic [7:0] plus_to_space(input logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] kind, input logic [7:0] data,
                                        input logic hv);
      rsp_type r;
      r.out_kind  = kind;
      r.out_byte  = data;
      r.has_value = hv;
      r.run_last  = 1'b0;
      return r;
   endfunction

endpackage

// ----- hdl/uqpd_front.sv -----
// Front end: accepts query bytes, tracks key/value mode and escapes, builds result bundles.
module uqpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                queue_full,
   input  uqpd_pkg::req_type   req_data,
   output logic                accept,
   output logic                bundle_write,
   output uqpd_pkg::bundle_type bundle
);
   import uqpd_pkg::*;

   logic       in_value_ff, in_value_in;
   logic [1:0] pending_count_ff, pending_count_in;
   logic [7:0] pending_byte_ff, pending_byte_in;

   logic [COUNT_W-1:0] nres;
   logic [7:0]         b;

   assign accept       = push && !queue_full;
   assign bundle_write = accept && (bundle.count != '0);

   // The first held escape byte is always the percent sign, so only the
   // second one is stored.
   always_comb begin
      nres             = '0;
      bundle           = '0;
      b                = req_data.in_byte;
      in_value_in      = in_value_ff;
      pending_count_in = pending_count_ff;
      pending_byte_in  = pending_byte_ff;

      if (b == CH_AMP) begin
         if (pending_count_in >= 2'd1) begin
            bundle.slot[nres[1:0]] = make_rsp(KIND_VALUE, CH_PCT, 1'b0);
            nres = nres + COUNT_W'(1);
         end
         if (pending_count_in >= 2'd2) begin
            bundle.slot[nres[1:0]] = make_rsp(KIND_VALUE, plus_to_space(pending_byte_in), 1'b0);
            nres = nres + COUNT_W'(1);
         end
         bundle.slot[nres[1:0]] = make_rsp(KIND_END, 8'h00, in_value_in);
         nres = nres + COUNT_W'(1);
         pending_count_in = 2'd0;
         in_value_in      = 1'b0;
      end else if (!in_value_in) begin
         if (b == CH_EQ) begin
            in_value_in = 1'b1;
         end else begin
            bundle.slot[nres[1:0]] = make_rsp(KIND_KEY, b, 1'b0);
            nres = nres + COUNT_W'(1);
         end
      end else if (pending_count_in == 2'd0) begin
         if (b == CH_PCT) begin
            pending_count_in = 2'd1;
         end else begin
            bundle.slot[nres[1:0]] = make_rsp(KIND_VALUE, plus_to_space(b), 1'b0);
            nres = nres + COUNT_W'(1);
         end
      end else if (pending_count_in == 2'd1) begin
         pending_byte_in  = b;
         pending_count_in = 2'd2;
      end else begin
         bundle.slot[nres[1:0]] = make_rsp(KIND_VALUE,
                                           {hex_nibble(pending_byte_in), hex_nibble(b)}, 1'b0);
         nres = nres + COUNT_W'(1);
         pending_count_in = 2'd0;
      end

      // The final byte of a query also closes the pair that is open.
      if (req_data.end_of_query) begin
         if (pending_count_in >= 2'd1) begin
            bundle.slot[nres[1:0]] = make_rsp(KIND_VALUE, CH_PCT, 1'b0);
            nres = nres + COUNT_W'(1);
         end
         if (pending_count_in >= 2'd2) begin
            bundle.slot[nres[1:0]] = make_rsp(KIND_VALUE, plus_to_space(pending_byte_in), 1'b0);
            nres = nres + COUNT_W'(1);
         end
         bundle.slot[nres[1:0]] = make_rsp(KIND_END, 8'h00, in_value_in);
         nres = nres + COUNT_W'(1);
         pending_count_in = 2'd0;
         in_value_in      = 1'b0;
      end

      if (nres != '0) begin
         bundle.slot[nres[1:0] - 2'd1].run_last = 1'b1;
      end
      bundle.count = nres;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff      <= 1'b0;
         pending_count_ff <= 2'd0;
      end else if (accept) begin
         in_value_ff      <= in_value_in;
         pending_count_ff <= pending_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pending_byte_ff <= pending_byte_in;
      end
   end

endmodule

// ----- hdl/uqpd_queue.sv -----
// Short queue of result bundles between the front and back ends.
module uqpd_queue #(
   parameter int DEPTH = uqpd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  uqpd_pkg::bundle_type wr_data,
   output logic                 full,
   input  logic                 rd_en,
   output uqpd_pkg::bundle_type rd_data,
   output logic                 empty
);
   import uqpd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/uqpd_back.sv -----
// Back end: sends the results of the head bundle one at a time into the output register.
module uqpd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  uqpd_pkg::bundle_type head,
   input  logic                 queue_empty,
   output logic                 queue_pop,
   output logic                 empty,
   input  logic                 pop,
   output uqpd_pkg::rsp_type    rsp_data
);
   import uqpd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff;
   logic       load;
   logic       last_slot;

   assign empty     = !valid_ff;
   assign rsp_data  = rsp_ff;
   assign load      = !queue_empty && (!valid_ff || pop);
   assign last_slot = ((COUNT_W'(idx_ff) + COUNT_W'(1)) == head.count);
   assign queue_pop = load && last_slot;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_slot ? 2'd0 : idx_ff + 2'd1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= head.slot[idx_ff];
      end
   end

endmodule

// ----- hdl/url_query_param_decoder_unit.sv -----
// The first result of an item passes through the bundle queue and then the output register
// before it is on the result ports, when the output register is free.
// Throughput: one item per cycle while each item causes at most one result and pop stays high;
// an item with several results holds the back end until all are sent, and the bundle queue
// (QUEUE_DEPTH) soaks up those bursts. Items that cause no result never enter the queue.
// Reset: synchronous, active high; clears key/value mode, held escape count, queue and output.
module url_query_param_decoder_unit #(
   parameter int QUEUE_DEPTH = uqpd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  uqpd_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output uqpd_pkg::rsp_type rsp_data
);
   import uqpd_pkg::*;

   bundle_type wr_bundle, head_bundle;
   logic       accept, bundle_write, queue_full, queue_empty, queue_pop;

   assign full = queue_full;

   uqpd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .queue_full   (queue_full),
      .req_data     (req_data),
      .accept       (accept),
      .bundle_write (bundle_write),
      .bundle       (wr_bundle)
   );

   uqpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_write && accept),
      .wr_data (wr_bundle),
      .full    (queue_full),
      .rd_en   (queue_pop),
      .rd_data (head_bundle),
      .empty   (queue_empty)
   );

   uqpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head_bundle),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- hdl/uqpd_checker.sv -----
// Port-level assertions for the query decoder, bound to the top level.
module uqpd_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input uqpd_pkg::rsp_type rsp_data
);
   import uqpd_pkg::*;

   // Reset leaves nothing queued and room for input.
   a_reset_clears: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not cleared by reset");

   // A result that waits is not replaced.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("waiting result changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.out_kind == KIND_KEY || rsp_data.out_kind == KIND_VALUE ||
                  rsp_data.out_kind == KIND_END))
      else $error("illegal result kind");

   // A pair end carries no byte; byte results never carry the equals flag.
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.out_kind == KIND_END |-> rsp_data.out_byte == 8'h00)
      else $error("pair end with nonzero byte");

   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.out_kind != KIND_END |-> !rsp_data.has_value)
      else $error("byte result with has_value set");

endmodule

bind url_query_param_decoder_unit uqpd_checker u_checker (.*);

// ----- sim/url_query_param_decoder_unit_tb.sv -----
// Self-checking testbench for the URL query parameter decoder: directed and random queries.
module url_query_param_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uqpd_pkg::*;

   class query_scoreboard;
      rsp_type     expected_q[$];
      rsp_type     burst[$];
      bit          in_value;
      int unsigned held_count;
      logic [7:0]  held[2];
      int unsigned mismatches;

      function new();
         in_value   = 1'b0;
         held_count = 0;
         held[0]    = 8'h00;
         held[1]    = 8'h00;
         mismatches = 0;
      endfunction

      function logic [3:0] digit_value(input logic [7:0] c);
         logic [3:0] v;
         v = 4'd0;
         if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
         end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
         end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
         end
         return v;
      endfunction

      function logic [7:0] unplus(input logic [7:0] c);
         return (c == CH_PLUS) ? CH_SPACE : c;
      endfunction

      function void add(input logic [1:0] kind, input logic [7:0] data, input logic hv);
         rsp_type r;
         r.out_kind  = kind;
         r.out_byte  = data;
         r.has_value = hv;
         r.run_last  = 1'b0;
         burst.push_back(r);
      endfunction

      // Held escape bytes leave before the end-of-pair marker, a held plus turned into a space.
      function void close_pair();
         if (held_count >= 1) add(KIND_VALUE, held[0], 1'b0);
         if (held_count >= 2) add(KIND_VALUE, unplus(held[1]), 1'b0);
         held_count = 0;
         add(KIND_END, 8'h00, in_value);
         in_value = 1'b0;
      endfunction

      function void note_request(input req_type r);
         burst.delete();
         if (r.in_byte == CH_AMP) begin
            close_pair();
         end else if (!in_value) begin
            if (r.in_byte == CH_EQ) in_value = 1'b1;
            else add(KIND_KEY, r.in_byte, 1'b0);
         end else if (held_count == 0) begin
            if (r.in_byte == CH_PCT) begin
               held[0]    = r.in_byte;
               held_count = 1;
            end else begin
               add(KIND_VALUE, unplus(r.in_byte), 1'b0);
            end
         end else if (held_count == 1) begin
            held[1]    = r.in_byte;
            held_count = 2;
         end else begin
            add(KIND_VALUE, {digit_value(held[1]), digit_value(r.in_byte)}, 1'b0);
            held_count = 0;
         end
         if (r.end_of_query) close_pair();
         if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
         foreach (burst[i]) expected_q.push_back(burst[i]);
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected item kind=%0d byte=%02h hv=%0b last=%0b", $realtime,
                        got.out_kind, got.out_byte, got.has_value, got.run_last);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
                got.has_value !== want.has_value || got.run_last !== want.run_last) begin
               if (mismatches < 10)
                  $display("%0t: expected kind=%0d byte=%02h hv=%0b last=%0b, got kind=%0d byte=%02h hv=%0b last=%0b",
                           $realtime, want.out_kind, want.out_byte, want.has_value,
                           want.run_last, got.out_kind, got.out_byte, got.has_value,
                           got.run_last);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   query_scoreboard sb = new();
   int unsigned     items_sent = 0;
   bit              quiet = 1'b0;

   url_query_param_decoder_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic send_item(input logic [7:0] data, input logic eoq);
      req_type r;
      int      gap;
      r.in_byte      = data;
      r.end_of_query = eoq;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            push <= 1'b0;
         end
      end
      @(negedge clock);
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      sb.note_request(r);
      items_sent++;
      if (items_sent >= 190) quiet = 1'b1;
   endtask

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(8'h30 + v);
      return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(8'h21, 8'h7E));
      if (c == CH_AMP || c == CH_EQ || c == CH_PCT || c == CH_PLUS) c = 8'h78;
      return c;
   endfunction

   // A query of one to four pairs; values mix escapes (some malformed or cut short), plus signs and plain text.
   task automatic send_query();
      logic [7:0] text[$];
      int         pairs;
      int         n;
      pairs = $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
         if (p > 0) text.push_back(CH_AMP);
         n = $urandom_range(0, 4);
         repeat (n) begin
            case ($urandom_range(0, 7))
               0: text.push_back(CH_PCT);
               1: text.push_back(CH_PLUS);
               default: text.push_back(plain_char());
            endcase
         end
         if ($urandom_range(0, 3) != 0) begin
            text.push_back(CH_EQ);
            n = $urandom_range(0, 5);
            repeat (n) begin
               case ($urandom_range(0, 7))
                  0, 1: begin
                     text.push_back(CH_PCT);
                     text.push_back(hex_char());
                     text.push_back(hex_char());
                  end
                  2: text.push_back(CH_PLUS);
                  3: text.push_back(CH_EQ);
                  4: begin
                     text.push_back(CH_PCT);
                     text.push_back(8'($urandom_range(0, 255)));
                     text.push_back(8'($urandom_range(0, 255)));
                  end
                  default: text.push_back(plain_char());
               endcase
            end
            // An escape cut short by the end of its pair.
            case ($urandom_range(0, 5))
               0: text.push_back(CH_PCT);
               1: begin
                  text.push_back(CH_PCT);
                  text.push_back($urandom_range(0, 1) ? CH_PLUS : hex_char());
               end
               default: ;
            endcase
         end
      end
      if ($urandom_range(0, 7) == 0) text.push_back(CH_AMP);
      if (text.size() == 0) text.push_back(plain_char());
      foreach (text[i]) send_item(text[i], i == text.size() - 1);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
   endtask

   // Result side: pop with random stall bursts, none once the run goes quiet.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            pop   <= 1'b0;
            stall = $urandom_range(1, 14) - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_response(rsp_data);
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Key bytes pass through, including percent and plus signs.
      send_item("k", 1'b0);
      send_item(CH_PCT, 1'b0);
      send_item(CH_PLUS, 1'b0);
      send_item(CH_EQ, 1'b0);
      // A second equals sign is an ordinary value byte.
      send_item(CH_EQ, 1'b0);
      send_item(CH_PCT, 1'b0);
      send_item("4", 1'b0);
      send_item("1", 1'b0);
      send_item(CH_PCT, 1'b0);
      send_item("f", 1'b0);
      send_item("F", 1'b0);
      send_item(CH_PLUS, 1'b0);
      // An ampersand flushes a half-finished escape, plus turned into space.
      send_item(CH_PCT, 1'b0);
      send_item(CH_PLUS, 1'b0);
      send_item(CH_AMP, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      // Escape digits that are not hex digits count as zero.
      send_item(CH_EQ, 1'b0);
      send_item(CH_PCT, 1'b0);
      send_item(CH_EQ, 1'b0);
      send_item("9", 1'b0);
      send_item(CH_PCT, 1'b1);
      // A final ampersand with an escape pending gives the largest burst.
      send_item(CH_EQ, 1'b0);
      send_item(CH_PCT, 1'b0);
      send_item("G", 1'b0);
      send_item(CH_AMP, 1'b1);

      while (items_sent < 230) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_query();
      end
      @(negedge clock);
      push <= 1'b0;
      quiet = 1'b1;

      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/uqpd_pkg.sv
hdl/uqpd_front.sv
hdl/uqpd_queue.sv
hdl/uqpd_back.sv
hdl/url_query_param_decoder_unit.sv
hdl/uqpd_checker.sv
sim/url_query_param_decoder_unit_tb.sv
